// ----- sv/baro_sensor_compensation_macros.svh -----
// Assertion helpers for the compensation block
`ifndef BARO_SENSOR_COMPENSATION_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_MACROS_SVH
`ifndef SYNTHESIS
`define BSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSC_ASSERT_NOW(label, ante, cons, msg)
`define BSC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- sv/bsc_pkg.sv -----
package bsc_pkg;

    localparam int RAW_W   = 20;
    localparam int VALUE_W = 32;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 64;

    localparam logic [CIDX_W-1:0] REG_TEMP_COEFFS = 2'd0;
    localparam logic [CIDX_W-1:0] REG_PRESS_LOW   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_PRESS_HIGH  = 2'd2;
    localparam logic [CIDX_W-1:0] REG_PRESS_NINE  = 2'd3;

    localparam logic MODE_TEMP  = 1'b0;
    localparam logic MODE_PRESS = 1'b1;

    function automatic logic [63:0] asr(input logic [63:0] v, input int n);
        return 64'($signed(v) >>> n);
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] v);
        logic [31:0] r;
        r = v[31:0];
        if (v[63] && v < 64'hFFFF_FFFF_8000_0000)
            r = 32'h8000_0000;
        else if (!v[63] && v > 64'h0000_0000_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        return r;
    endfunction

endpackage

// ----- sv/bsc_in_if.sv -----
interface bsc_in_if;
    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [bsc_pkg::RAW_W-1:0]       raw_sample;

    modport source (output valid, output mode, output raw_sample, input ready);
    modport sink   (input valid, input mode, input raw_sample, output ready);
endinterface

// ----- sv/bsc_out_if.sv -----
interface bsc_out_if;
    logic                               valid;
    logic                               ready;
    logic                               result_kind;
    logic signed [bsc_pkg::VALUE_W-1:0] value;
    logic                               zero_divisor;

    modport source (output valid, output result_kind, output value, output zero_divisor,
                    input ready);
    modport sink   (input valid, input result_kind, input value, input zero_divisor,
                    output ready);
endinterface

// ----- sv/bsc_cfg_if.sv -----
interface bsc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bsc_pkg::CIDX_W-1:0]    index;
    logic [bsc_pkg::CDATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/baro_sensor_compensation.sv -----
// Channel   Dir   Payload                              Request taken when
// sample    in    mode, raw_sample                     valid & ready
// result    out   result_kind, value, zero_divisor     valid & ready
// cfg       in    index, data                          valid & ready (always ready)
//
// One shared 64x16 multiplier builds each 64-bit product by shift and add over
// 16-bit slices of its second operand. Temperature: 3 products. Pressure: 10
// products and a 64-step restoring divide, skipped when the divisor is zero.
// A new request is taken only in IDLE, after the last result is registered.
// rst_n clears coefficients, fine temperature and control. A held result stalls
// only the final writeback.
`include "baro_sensor_compensation_macros.svh"

module baro_sensor_compensation (
    input  logic         clk,
    input  logic         rst_n,
    bsc_in_if.sink       sample,
    bsc_out_if.source    result,
    bsc_cfg_if.sink      cfg
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_T0   = 5'd1;
    localparam logic [4:0] ST_T1   = 5'd2;
    localparam logic [4:0] ST_T2   = 5'd3;
    localparam logic [4:0] ST_T3   = 5'd4;
    localparam logic [4:0] ST_P0   = 5'd5;
    localparam logic [4:0] ST_P1   = 5'd6;
    localparam logic [4:0] ST_P2   = 5'd7;
    localparam logic [4:0] ST_P3   = 5'd8;
    localparam logic [4:0] ST_P4   = 5'd9;
    localparam logic [4:0] ST_P5   = 5'd10;
    localparam logic [4:0] ST_P6   = 5'd11;
    localparam logic [4:0] ST_P7   = 5'd12;
    localparam logic [4:0] ST_DSET = 5'd13;
    localparam logic [4:0] ST_DIV  = 5'd14;
    localparam logic [4:0] ST_DFIX = 5'd15;
    localparam logic [4:0] ST_P9   = 5'd16;
    localparam logic [4:0] ST_P10  = 5'd17;
    localparam logic [4:0] ST_P11  = 5'd18;
    localparam logic [4:0] ST_P12  = 5'd19;
    localparam logic [4:0] ST_OUT  = 5'd20;

    logic [4:0]  state_reg, state_next;
    logic [47:0] tc_reg, tc_next;
    logic [63:0] pl_reg, pl_next;
    logic [63:0] ph_reg, ph_next;
    logic [15:0] p9_reg, p9_next;
    logic [31:0] fine_reg, fine_next;

    logic                       mode_reg, mode_next;
    logic [bsc_pkg::RAW_W-1:0]  raw_reg, raw_next;
    logic [63:0] ra_reg, ra_next, rb_reg, rb_next, rc_reg, rc_next, rp_reg, rp_next;
    logic [31:0] fin_reg, fin_next;
    logic        zero_reg, zero_next;

    logic        mul_run_reg, mul_run_next;
    logic        mul_done_reg, mul_done_next;
    logic [1:0]  mul_cnt_reg, mul_cnt_next;
    logic [63:0] mx_reg, mx_next, my_reg, my_next, acc_reg, acc_next;
    logic [63:0] mul_x, mul_y, part;
    logic        mul_op, mul_start;

    logic [63:0] dq_reg, dq_next, drem_reg, drem_next, dd_reg, dd_next;
    logic        dneg_reg, dneg_next;
    logic [5:0]  dcnt_reg, dcnt_next;
    logic [64:0] dsh;

    logic        ovalid_reg, ovalid_next;
    logic        okind_reg, okind_next;
    logic [31:0] oval_reg, oval_next;
    logic        ozero_reg, ozero_next;

    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, qv, tmp;

    assign t1 = {48'd0, tc_reg[15:0]};
    assign t2 = bsc_pkg::sx16(tc_reg[31:16]);
    assign t3 = bsc_pkg::sx16(tc_reg[47:32]);
    assign p1 = {48'd0, pl_reg[15:0]};
    assign p2 = bsc_pkg::sx16(pl_reg[31:16]);
    assign p3 = bsc_pkg::sx16(pl_reg[47:32]);
    assign p4 = bsc_pkg::sx16(pl_reg[63:48]);
    assign p5 = bsc_pkg::sx16(ph_reg[15:0]);
    assign p6 = bsc_pkg::sx16(ph_reg[31:16]);
    assign p7 = bsc_pkg::sx16(ph_reg[47:32]);
    assign p8 = bsc_pkg::sx16(ph_reg[63:48]);
    assign p9 = bsc_pkg::sx16(p9_reg);
    assign qv = bsc_pkg::asr(rp_reg, 13);

    assign part = 64'(mx_reg * my_reg[15:0]);
    assign dsh  = {drem_reg, dq_reg[63]};

    assign sample.ready        = (state_reg == ST_IDLE);
    assign cfg.ready           = 1'b1;
    assign result.valid        = ovalid_reg;
    assign result.result_kind  = okind_reg;
    assign result.value        = oval_reg;
    assign result.zero_divisor = ozero_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_op = 1'b1;
        mul_x  = ra_reg;
        mul_y  = ra_reg;
        case (state_reg)
            ST_T0:
            begin
                mul_x = {47'd0, raw_reg[19:3]} - (t1 << 1);
                mul_y = t2;
            end
            ST_T1:
            begin
                mul_x = {48'd0, raw_reg[19:4]} - t1;
                mul_y = {48'd0, raw_reg[19:4]} - t1;
            end
            ST_T2:  begin mul_x = rc_reg; mul_y = t3; end
            ST_P0:  begin mul_x = ra_reg; mul_y = ra_reg; end
            ST_P1:  begin mul_x = rc_reg; mul_y = p6; end
            ST_P2:  begin mul_x = ra_reg; mul_y = p5; end
            ST_P3:  begin mul_x = rc_reg; mul_y = p3; end
            ST_P4:  begin mul_x = ra_reg; mul_y = p2; end
            ST_P5:  begin mul_x = 64'h0000_8000_0000_0000 + rc_reg; mul_y = p1; end
            ST_P7:  begin mul_x = (rp_reg << 31) - rb_reg; mul_y = 64'd3125; end
            ST_P9:  begin mul_x = p9; mul_y = qv; end
            ST_P10: begin mul_x = rc_reg; mul_y = qv; end
            ST_P11: begin mul_x = p8; mul_y = rp_reg; end
            default: mul_op = 1'b0;
        endcase
    end

    assign mul_start = mul_op && !mul_run_reg && !mul_done_reg;

    always_comb
    begin
        state_next    = state_reg;
        tc_next       = tc_reg;
        pl_next       = pl_reg;
        ph_next       = ph_reg;
        p9_next       = p9_reg;
        fine_next     = fine_reg;
        mode_next     = mode_reg;
        raw_next      = raw_reg;
        ra_next       = ra_reg;
        rb_next       = rb_reg;
        rc_next       = rc_reg;
        rp_next       = rp_reg;
        fin_next      = fin_reg;
        zero_next     = zero_reg;
        mul_run_next  = mul_run_reg;
        mul_done_next = 1'b0;
        mul_cnt_next  = mul_cnt_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        acc_next      = acc_reg;
        dq_next       = dq_reg;
        drem_next     = drem_reg;
        dd_next       = dd_reg;
        dneg_next     = dneg_reg;
        dcnt_next     = dcnt_reg;
        ovalid_next   = ovalid_reg;
        okind_next    = okind_reg;
        oval_next     = oval_reg;
        ozero_next    = ozero_reg;
        tmp           = 64'd0;

        if (cfg.valid)
        begin
            case (cfg.index)
                bsc_pkg::REG_TEMP_COEFFS: tc_next = cfg.data[47:0];
                bsc_pkg::REG_PRESS_LOW:   pl_next = cfg.data;
                bsc_pkg::REG_PRESS_HIGH:  ph_next = cfg.data;
                bsc_pkg::REG_PRESS_NINE:  p9_next = cfg.data[15:0];
                default: ;
            endcase
        end

        if (result.ready)
            ovalid_next = 1'b0;

        // 64x16 step per cycle, low 64 bits kept
        if (mul_start)
        begin
            mx_next      = mul_x;
            my_next      = mul_y;
            acc_next     = 64'd0;
            mul_cnt_next = 2'd0;
            mul_run_next = 1'b1;
        end
        else if (mul_run_reg)
        begin
            acc_next     = acc_reg + part;
            mx_next      = mx_reg << 16;
            my_next      = my_reg >> 16;
            mul_cnt_next = mul_cnt_reg + 2'd1;
            if (mul_cnt_reg == 2'd3)
            begin
                mul_run_next  = 1'b0;
                mul_done_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    mode_next = sample.mode;
                    raw_next  = sample.raw_sample;
                    ra_next   = {{32{fine_reg[31]}}, fine_reg} - 64'd128000;
                    state_next = (sample.mode == bsc_pkg::MODE_PRESS) ? ST_P0 : ST_T0;
                end
            end
            ST_T0: if (mul_done_reg) begin rb_next = bsc_pkg::asr(acc_reg, 11); state_next = ST_T1; end
            ST_T1: if (mul_done_reg) begin rc_next = bsc_pkg::asr(acc_reg, 12); state_next = ST_T2; end
            ST_T2:
            begin
                if (mul_done_reg)
                begin
                    ra_next    = rb_reg + bsc_pkg::asr(acc_reg, 14);
                    state_next = ST_T3;
                end
            end
            ST_T3:
            begin
                fine_next  = ra_reg[31:0];
                tmp        = (ra_reg << 2) + ra_reg + 64'd128;
                fin_next   = tmp[39:8];
                zero_next  = 1'b0;
                state_next = ST_OUT;
            end
            ST_P0: if (mul_done_reg) begin rc_next = acc_reg; state_next = ST_P1; end
            ST_P1: if (mul_done_reg) begin rb_next = acc_reg; state_next = ST_P2; end
            ST_P2:
            begin
                if (mul_done_reg)
                begin
                    rb_next    = rb_reg + (acc_reg << 17) + (p4 << 35);
                    state_next = ST_P3;
                end
            end
            ST_P3: if (mul_done_reg) begin rc_next = bsc_pkg::asr(acc_reg, 8); state_next = ST_P4; end
            ST_P4: if (mul_done_reg) begin rc_next = rc_reg + (acc_reg << 12); state_next = ST_P5; end
            ST_P5:
            begin
                if (mul_done_reg)
                begin
                    ra_next    = bsc_pkg::asr(acc_reg, 33);
                    rp_next    = 64'd1048576 - {44'd0, raw_reg};
                    state_next = ST_P6;
                end
            end
            ST_P6:
            begin
                if (ra_reg == 64'd0)
                begin
                    fin_next   = 32'd0;
                    zero_next  = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    zero_next  = 1'b0;
                    state_next = ST_P7;
                end
            end
            ST_P7: if (mul_done_reg) begin rp_next = acc_reg; state_next = ST_DSET; end
            ST_DSET:
            begin
                dq_next    = rp_reg[63] ? (64'd0 - rp_reg) : rp_reg;
                dd_next    = ra_reg[63] ? (64'd0 - ra_reg) : ra_reg;
                dneg_next  = rp_reg[63] ^ ra_reg[63];
                drem_next  = 64'd0;
                dcnt_next  = 6'd0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (dsh >= {1'b0, dd_reg})
                begin
                    tmp       = 64'(dsh - {1'b0, dd_reg});
                    drem_next = tmp;
                    dq_next   = {dq_reg[62:0], 1'b1};
                end
                else
                begin
                    drem_next = dsh[63:0];
                    dq_next   = {dq_reg[62:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'd63)
                    state_next = ST_DFIX;
            end
            ST_DFIX:
            begin
                rp_next    = dneg_reg ? (64'd0 - dq_reg) : dq_reg;
                state_next = ST_P9;
            end
            ST_P9:  if (mul_done_reg) begin rc_next = acc_reg; state_next = ST_P10; end
            ST_P10: if (mul_done_reg) begin ra_next = bsc_pkg::asr(acc_reg, 25); state_next = ST_P11; end
            ST_P11: if (mul_done_reg) begin rb_next = bsc_pkg::asr(acc_reg, 19); state_next = ST_P12; end
            ST_P12:
            begin
                tmp        = bsc_pkg::asr(rp_reg + ra_reg + rb_reg, 8) + (p7 << 4);
                fin_next   = bsc_pkg::sat32(tmp);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || result.ready)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = mode_reg;
                    oval_next   = fin_reg;
                    ozero_next  = zero_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tc_reg       <= '0;
            pl_reg       <= '0;
            ph_reg       <= '0;
            p9_reg       <= '0;
            fine_reg     <= '0;
            mul_run_reg  <= 1'b0;
            mul_done_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tc_reg       <= tc_next;
            pl_reg       <= pl_next;
            ph_reg       <= ph_next;
            p9_reg       <= p9_next;
            fine_reg     <= fine_next;
            mul_run_reg  <= mul_run_next;
            mul_done_reg <= mul_done_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        raw_reg     <= raw_next;
        ra_reg      <= ra_next;
        rb_reg      <= rb_next;
        rc_reg      <= rc_next;
        rp_reg      <= rp_next;
        fin_reg     <= fin_next;
        zero_reg    <= zero_next;
        mul_cnt_reg <= mul_cnt_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        acc_reg     <= acc_next;
        dq_reg      <= dq_next;
        drem_reg    <= drem_next;
        dd_reg      <= dd_next;
        dneg_reg    <= dneg_next;
        dcnt_reg    <= dcnt_next;
        okind_reg   <= okind_next;
        oval_reg    <= oval_next;
        ozero_reg   <= ozero_next;
    end

    `BSC_ASSERT_NOW(a_zero_value, result.valid && result.zero_divisor, result.value == 32'sd0 && result.result_kind == bsc_pkg::MODE_PRESS, "zero divisor with nonzero value")
    `BSC_ASSERT_NOW(a_temp_flag, result.valid && result.result_kind == bsc_pkg::MODE_TEMP, !result.zero_divisor, "temperature result flags zero divisor")
    `BSC_ASSERT_NOW(a_mul_div, state_reg == ST_DIV, !mul_run_reg, "multiplier busy during divide")
    `BSC_ASSERT_NEXT(a_busy, sample.valid && sample.ready, !sample.ready, "new request taken while busy")

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic                          kind;
        logic [bsc_pkg::VALUE_W-1:0]   value;
        logic                          zero;
    } comp_result_t;

    typedef struct {
        bit                            is_cfg;
        logic [bsc_pkg::CIDX_W-1:0]    idx;
        logic [bsc_pkg::CDATA_W-1:0]   data;
        logic                          mode;
        logic [bsc_pkg::RAW_W-1:0]     raw;
        bit                            has_lit;
        logic [bsc_pkg::VALUE_W-1:0]   lit_value;
        logic                          lit_zero;
    } stim_row_t;

    logic clk;
    logic rst_n;

    bsc_in_if  sample_bus();
    bsc_out_if result_bus();
    bsc_cfg_if cfg_bus();

    baro_sensor_compensation i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // predictor copy of the coefficient registers and the fine temperature
    logic [47:0]        cal_temp;
    logic [63:0]        cal_press_lo;
    logic [63:0]        cal_press_hi;
    logic [15:0]        cal_p9;
    logic [31:0]        fine_t;

    comp_result_t       expected_q[$];
    stim_row_t          dir_rows[$];
    int                 mismatches = 0;
    bit                 burst_mode = 0;
    bit                 long_hold = 0;
    bit                 hold_go = 0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [63:0] sra64(input logic [63:0] v, input int n);
        logic signed [63:0] s;
        s = v;
        return s >>> n;
    endfunction

    function automatic logic [63:0] sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        ma = a[63] ? 64'd0 - a : a;
        mb = b[63] ? 64'd0 - b : b;
        q  = ma / mb;
        return (a[63] != b[63]) ? 64'd0 - q : q;
    endfunction

    function automatic logic [31:0] clamp32(input logic [63:0] v);
        if (v[63] && v < 64'hFFFF_FFFF_8000_0000)
            return 32'h8000_0000;
        if (!v[63] && v > 64'h0000_0000_7FFF_FFFF)
            return 32'h7FFF_FFFF;
        return v[31:0];
    endfunction

    function automatic comp_result_t compensate(input logic m,
                                                input logic [bsc_pkg::RAW_W-1:0] raw_in);
        comp_result_t r;
        logic [63:0] raw, t1, t2, t3, v1, v2, d, f;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, q;
        raw = {44'd0, raw_in};
        r.kind = m;
        r.zero = 1'b0;
        if (m == bsc_pkg::MODE_TEMP)
        begin
            t1 = {48'd0, cal_temp[15:0]};
            t2 = sext16(cal_temp[31:16]);
            t3 = sext16(cal_temp[47:32]);
            v1 = sra64(((raw >> 3) - (t1 << 1)) * t2, 11);
            d  = (raw >> 4) - t1;
            v2 = sra64(sra64(d * d, 12) * t3, 14);
            f  = v1 + v2;
            fine_t  = f[31:0];
            f  = sra64(f * 64'd5 + 64'd128, 8);
            r.value = f[31:0];
        end
        else
        begin
            p1 = {48'd0, cal_press_lo[15:0]};
            p2 = sext16(cal_press_lo[31:16]);
            p3 = sext16(cal_press_lo[47:32]);
            p4 = sext16(cal_press_lo[63:48]);
            p5 = sext16(cal_press_hi[15:0]);
            p6 = sext16(cal_press_hi[31:16]);
            p7 = sext16(cal_press_hi[47:32]);
            p8 = sext16(cal_press_hi[63:48]);
            p9 = sext16(cal_p9);
            a = {{32{fine_t[31]}}, fine_t} - 64'd128000;
            b = a * a * p6;
            b = b + ((a * p5) << 17);
            b = b + (p4 << 35);
            a = sra64(a * a * p3, 8) + ((a * p2) << 12);
            a = sra64(((64'd1 << 47) + a) * p1, 33);
            if (a == 64'd0)
            begin
                r.zero  = 1'b1;
                r.value = '0;
            end
            else
            begin
                p = 64'd1048576 - raw;
                p = div_trunc(((p << 31) - b) * 64'd3125, a);
                q = sra64(p, 13);
                a = sra64(p9 * q * q, 25);
                b = sra64(p8 * p, 19);
                p = sra64(p + a + b, 8) + (p7 << 4);
                r.value = clamp32(p);
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // entered at a rising edge; leaves at the edge where the request is taken
    task automatic push_sample(input logic m, input logic [bsc_pkg::RAW_W-1:0] raw,
                               input bit has_lit,
                               input logic [bsc_pkg::VALUE_W-1:0] lit_v,
                               input logic lit_z);
        int g;
        bit taken;
        comp_result_t e;
        g = pick_gap();
        if (g > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        sample_bus.valid      <= 1'b1;
        sample_bus.mode       <= m;
        sample_bus.raw_sample <= raw;
        do
        begin
            @(negedge clk);
            taken = sample_bus.ready;
            @(posedge clk);
        end while (!taken);
        e = compensate(m, raw);
        if (has_lit)
        begin
            e.value = lit_v;
            e.zero  = lit_z;
        end
        expected_q.push_back(e);
    endtask

    task automatic write_reg(input logic [bsc_pkg::CIDX_W-1:0] idx,
                             input logic [bsc_pkg::CDATA_W-1:0] data);
        bit taken;
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
        begin
            @(negedge clk);
            taken = cfg_bus.ready;
            @(posedge clk);
        end while (!taken);
        cfg_bus.valid <= 1'b0;
        case (idx)
            bsc_pkg::REG_TEMP_COEFFS: cal_temp     = data[47:0];
            bsc_pkg::REG_PRESS_LOW:   cal_press_lo = data;
            bsc_pkg::REG_PRESS_HIGH:  cal_press_hi = data;
            bsc_pkg::REG_PRESS_NINE:  cal_p9       = data[15:0];
            default: ;
        endcase
    endtask

    task automatic drain(input int extra);
        sample_bus.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic load_coeffs(input logic [63:0] t, input logic [63:0] lo,
                               input logic [63:0] hi, input logic [63:0] nine);
        drain(8);
        write_reg(bsc_pkg::REG_TEMP_COEFFS, t);
        write_reg(bsc_pkg::REG_PRESS_LOW, lo);
        write_reg(bsc_pkg::REG_PRESS_HIGH, hi);
        write_reg(bsc_pkg::REG_PRESS_NINE, nine);
        @(posedge clk);
    endtask

    function automatic void add_row(input bit is_cfg, input logic [bsc_pkg::CIDX_W-1:0] idx,
                                    input logic [bsc_pkg::CDATA_W-1:0] data, input logic m,
                                    input logic [bsc_pkg::RAW_W-1:0] raw, input bit has_lit,
                                    input logic [bsc_pkg::VALUE_W-1:0] lv, input logic lz);
        stim_row_t s;
        s.is_cfg = is_cfg; s.idx = idx; s.data = data; s.mode = m; s.raw = raw;
        s.has_lit = has_lit; s.lit_value = lv; s.lit_zero = lz;
        dir_rows.push_back(s);
    endfunction

    // result side: sample at the falling edge, act at the rising edge
    initial
    begin : result_side
        comp_result_t got, want;
        bit seen;
        int stall;
        stall = 0;
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            seen = result_bus.valid && result_bus.ready && rst_n;
            got.kind  = result_bus.result_kind;
            got.value = result_bus.value;
            got.zero  = result_bus.zero_divisor;
            @(posedge clk);
            if (seen)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result kind=%0d value=%0d zero=%0d",
                                 got.kind, $signed(got.value), got.zero);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value ||
                        got.zero !== want.zero)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp kind=%0d value=%0d zero=%0d, got kind=%0d value=%0d zero=%0d",
                                     want.kind, $signed(want.value), want.zero,
                                     got.kind, $signed(got.value), got.zero);
                    end
                end
            end
            if (long_hold)
                result_bus.ready <= 1'b0;
            else if (stall > 0)
            begin
                stall--;
                result_bus.ready <= 1'b0;
            end
            else if (burst_mode)
                result_bus.ready <= 1'b1;
            else
            begin
                stall = pick_gap();
                result_bus.ready <= (stall == 0);
            end
        end
    end

    // long back-pressure so the block fills and stalls the sample channel
    initial
    begin : hold_off
        wait (hold_go);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin : timeout
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        logic [63:0] t, lo, hi, nine;
        logic [bsc_pkg::RAW_W-1:0] raw;
        logic m;
        int r;
        cal_temp = '0; cal_press_lo = '0; cal_press_hi = '0; cal_p9 = '0; fine_t = '0;
        rst_n = 1'b0;
        sample_bus.valid = 1'b0;
        sample_bus.mode = bsc_pkg::MODE_TEMP;
        sample_bus.raw_sample = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = bsc_pkg::REG_TEMP_COEFFS;
        cfg_bus.data = '0;

        // zero coefficients: temperature is 0, pressure divisor is 0
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_TEMP,  20'h00000,
                1'b1, 32'd0, 1'b0);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_TEMP,  20'hFFFFF,
                1'b1, 32'd0, 1'b0);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_PRESS, 20'h00000,
                1'b1, 32'd0, 1'b1);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_PRESS, 20'hFFFFF,
                1'b1, 32'd0, 1'b1);
        add_row(1'b1, bsc_pkg::REG_TEMP_COEFFS, 64'hFC18_6743_6B70, bsc_pkg::MODE_TEMP,
                20'd0, 1'b0, 32'd0, 1'b0);
        add_row(1'b1, bsc_pkg::REG_PRESS_LOW,   64'h0B27_0BD0_D643_8E7D, bsc_pkg::MODE_TEMP,
                20'd0, 1'b0, 32'd0, 1'b0);
        add_row(1'b1, bsc_pkg::REG_PRESS_HIGH,  64'hC6F8_3C8C_FFF9_008C, bsc_pkg::MODE_TEMP,
                20'd0, 1'b0, 32'd0, 1'b0);
        add_row(1'b1, bsc_pkg::REG_PRESS_NINE,  64'h1770, bsc_pkg::MODE_TEMP,
                20'd0, 1'b0, 32'd0, 1'b0);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_TEMP,  20'd519888,
                1'b0, 32'd0, 1'b0);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_PRESS, 20'd415148,
                1'b0, 32'd0, 1'b0);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_TEMP,  20'h00000,
                1'b0, 32'd0, 1'b0);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_PRESS, 20'hFFFFF,
                1'b0, 32'd0, 1'b0);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_TEMP,  20'hFFFFF,
                1'b0, 32'd0, 1'b0);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_PRESS, 20'h00000,
                1'b0, 32'd0, 1'b0);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_PRESS, 20'h80000,
                1'b0, 32'd0, 1'b0);
        add_row(1'b1, bsc_pkg::REG_TEMP_COEFFS, 64'hFFFF_FFFF_FFFF, bsc_pkg::MODE_TEMP,
                20'd0, 1'b0, 32'd0, 1'b0);
        add_row(1'b1, bsc_pkg::REG_PRESS_LOW,   64'hFFFF_FFFF_FFFF_FFFF, bsc_pkg::MODE_TEMP,
                20'd0, 1'b0, 32'd0, 1'b0);
        add_row(1'b1, bsc_pkg::REG_PRESS_HIGH,  64'hFFFF_FFFF_FFFF_FFFF, bsc_pkg::MODE_TEMP,
                20'd0, 1'b0, 32'd0, 1'b0);
        add_row(1'b1, bsc_pkg::REG_PRESS_NINE,  64'h8000, bsc_pkg::MODE_TEMP,
                20'd0, 1'b0, 32'd0, 1'b0);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_TEMP,  20'h00000,
                1'b0, 32'd0, 1'b0);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_PRESS, 20'h00000,
                1'b0, 32'd0, 1'b0);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_TEMP,  20'hFFFFF,
                1'b0, 32'd0, 1'b0);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_PRESS, 20'hFFFFF,
                1'b0, 32'd0, 1'b0);
        add_row(1'b0, bsc_pkg::REG_TEMP_COEFFS, 64'd0, bsc_pkg::MODE_PRESS, 20'd12345,
                1'b0, 32'd0, 1'b0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                drain(8);
                write_reg(dir_rows[i].idx, dir_rows[i].data);
                @(posedge clk);
            end
            else
                push_sample(dir_rows[i].mode, dir_rows[i].raw, dir_rows[i].has_lit,
                            dir_rows[i].lit_value, dir_rows[i].lit_zero);
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: begin t = 64'hFC18_6743_6B70; lo = 64'h0B27_0BD0_D643_8E7D;
                         hi = 64'hC6F8_3C8C_FFF9_008C; nine = 64'h1770; end
                1: begin t = 64'h7FFF_7FFF_FFFF; lo = 64'h7FFF_7FFF_7FFF_FFFF;
                         hi = 64'h7FFF_7FFF_7FFF_7FFF; nine = 64'h7FFF; end
                2: begin t = 64'h8000_8000_0000; lo = 64'h8000_8000_8000_0001;
                         hi = 64'h8000_8000_8000_8000; nine = 64'h8000; end
                3: begin t = {$urandom, $urandom}; lo = {$urandom, $urandom} & ~64'hFFFF;
                         hi = {$urandom, $urandom}; nine = {32'd0, $urandom}; end
                default: begin t = {$urandom, $urandom}; lo = {$urandom, $urandom};
                         hi = {$urandom, $urandom}; nine = {$urandom, $urandom}; end
            endcase
            load_coeffs(t, lo, hi, nine);
            burst_mode = (ph % 4 == 2);
            for (int k = 0; k < 125; k++)
            begin
                if (ph == 1 && k == 10)
                    hold_go = 1;
                r = $urandom_range(0, 99);
                if (r < 80)
                    m = k[0] ? bsc_pkg::MODE_PRESS : bsc_pkg::MODE_TEMP;
                else
                    m = 1'($urandom_range(0, 1));
                r = $urandom_range(0, 99);
                if (r < 5)
                    raw = 20'h00000;
                else if (r < 10)
                    raw = 20'hFFFFF;
                else if (r < 50)
                    raw = 20'(300000 + $urandom_range(0, 300000));
                else
                    raw = 20'($urandom);
                push_sample(m, raw, 1'b0, 32'd0, 1'b0);
            end
            burst_mode = 0;
        end

        drain(200);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
